@@ hw/rtl/lca_pkg.sv @@
// Shared types and constants for the binary-lifting common ancestor engine.
// Used by the top level; has no dependencies of its own.
package lca_pkg;

  // Field widths of the stream words and the configuration register.
  localparam int NodeFieldW   = 10;
  localparam int ParentFieldW = 11;
  localparam int DepthFieldW  = 10;
  localparam int AncestorW    = 11;
  localparam int NodeCountW   = 11;
  localparam int InDataW      = 48;
  localparam int OutDataW     = 16;

  localparam int NodesDefault  = 1024;
  localparam int LevelsDefault = 10;

  localparam logic [NodeCountW-1:0] NodeCountReset = 11'd1024;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BRD1,
    ST_BRD2,
    ST_BWR,
    ST_QDEP,
    ST_LIFT,
    ST_LIFTW,
    ST_CHECK,
    ST_DOWN,
    ST_DOWNW,
    ST_FINRD,
    ST_FINW,
    ST_FINISH
  } state_e;

endpackage

@@ hw/rtl/lca_ram.sv @@
// Generic synchronous RAM: one write port and two read ports, read data registered.
// No dependencies.
module lca_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_a_i,
  output logic [Width-1:0]                       rdata_a_o,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_b_i,
  output logic [Width-1:0]                       rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ hw/rtl/lowest_common_ancestor_engine_unit.sv @@
// Binary-lifting common ancestor engine; uses lca_pkg and two lca_ram instances.
// Load and no-op words go from input accept straight to the finish state. Build:
// read, read, write per entry; (LEVELS-1) * min(node_count, NODES-1) entries.
// Query: depth read, lift of the deeper node, top-down pass over all levels and a
// final parent read; the pass is skipped when one node is the other's ancestor.
// One word in work at a time; reset clears control, sets node_count to 1024, not RAMs.
module lowest_common_ancestor_engine_unit #(
  parameter int NODES  = lca_pkg::NodesDefault,
  parameter int LEVELS = lca_pkg::LevelsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lca_pkg::NodeCountW-1:0]       cfg_wdata_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // first_node [9:0], second_node [19:10], node_parent [30:20], node_depth [40:31]
  input  logic [lca_pkg::InDataW-1:0]          s_axis_tdata_i,
  // operation [1:0]
  input  logic [1:0]                           s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // ancestor [10:0]
  output logic [lca_pkg::OutDataW-1:0]         m_axis_tdata_o,
  // was_query [0]
  output logic [0:0]                           m_axis_tuser_o
);

  localparam int NodeW   = $clog2(NODES);
  localparam int EntW    = NodeW + 1;
  localparam int LvlW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int JtDepth = LEVELS * (2 ** NodeW);
  localparam int JtAw    = $clog2(JtDepth);
  localparam int CmpW    = 18;

  localparam logic [EntW-1:0] EntNone      = {1'b1, {NodeW{1'b0}}};
  localparam logic [LvlW-1:0] LvlLast      = LvlW'(LEVELS - 1);
  localparam logic [LvlW-1:0] LvlBuildLast = LvlW'((LEVELS > 1) ? LEVELS - 2 : 0);
  localparam logic [CmpW-1:0] NodesCmp     = CmpW'(NODES);
  localparam logic [CmpW-1:0] NodeMaxCmp   = CmpW'(NODES - 1);

  // Input word fields.
  lca_pkg::op_e                          in_op;
  logic [lca_pkg::NodeFieldW-1:0]        in_first;
  logic [lca_pkg::NodeFieldW-1:0]        in_second;
  logic [lca_pkg::ParentFieldW-1:0]      in_parent;
  logic [lca_pkg::DepthFieldW-1:0]       in_depth;
  logic                                  in_first_ok;
  logic                                  in_second_ok;
  logic [EntW-1:0]                       in_parent_ent;
  logic [CmpW-1:0]                       cnt_cmp;
  logic [CmpW-1:0]                       last_cmp;

  assign in_op     = lca_pkg::op_e'(s_axis_tuser_i);
  assign in_first  = s_axis_tdata_i[9:0];
  assign in_second = s_axis_tdata_i[19:10];
  assign in_parent = s_axis_tdata_i[30:20];
  assign in_depth  = s_axis_tdata_i[40:31];

  assign in_first_ok  = CmpW'(in_first) < NodesCmp;
  assign in_second_ok = CmpW'(in_second) < NodesCmp;

  // Negative and out-of-range parents are both stored as "none".
  always_comb begin
    if (in_parent[lca_pkg::ParentFieldW-1] || (CmpW'(in_parent) >= NodesCmp)) begin
      in_parent_ent = EntNone;
    end else begin
      in_parent_ent = {1'b0, NodeW'(in_parent)};
    end
  end

  // Registers.
  lca_pkg::state_e                 state_q, state_d;
  logic [lca_pkg::NodeCountW-1:0]  node_count_q;
  logic                            out_valid_q, out_valid_d;
  logic [lca_pkg::AncestorW-1:0]   out_anc_q, out_anc_d;
  logic                            out_query_q, out_query_d;
  logic [LvlW-1:0]                 k_q, k_d;
  logic [NodeW-1:0]                v_q, v_d;
  logic [NodeW-1:0]                last_q, last_d;
  logic [EntW-1:0]                 a_q, a_d;
  logic [EntW-1:0]                 b_q, b_d;
  logic [EntW-1:0]                 p_q, p_d;
  logic [EntW-1:0]                 res_q, res_d;
  logic                            query_q, query_d;
  logic [LEVELS-1:0]               diff_q, diff_d;

  assign cnt_cmp  = CmpW'(node_count_q);
  assign last_cmp = (cnt_cmp > NodeMaxCmp) ? NodeMaxCmp : cnt_cmp;

  // Memory ports.
  logic                            jt_we;
  logic [JtAw-1:0]                 jt_waddr;
  logic [EntW-1:0]                 jt_wdata;
  logic [JtAw-1:0]                 jt_raddr_a;
  logic [JtAw-1:0]                 jt_raddr_b;
  logic [EntW-1:0]                 jt_rdata_a;
  logic [EntW-1:0]                 jt_rdata_b;
  logic                            dep_we;
  logic [NodeW-1:0]                dep_waddr;
  logic [lca_pkg::DepthFieldW-1:0] dep_wdata;
  logic [NodeW-1:0]                dep_raddr_a;
  logic [NodeW-1:0]                dep_raddr_b;
  logic [lca_pkg::DepthFieldW-1:0] dep_rdata_a;
  logic [lca_pkg::DepthFieldW-1:0] dep_rdata_b;

  // Helpers.
  logic [LvlW-1:0]                 k_inc;
  logic [LvlW-1:0]                 k_dec;
  logic [lca_pkg::DepthFieldW-1:0] dep_diff;
  logic [EntW-1:0]                 hop_a;
  logic [EntW-1:0]                 hop_b;

  assign k_inc = k_q + LvlW'(1);
  assign k_dec = k_q - LvlW'(1);
  // A hop from "none" stays "none"; the register addressed is still held.
  assign hop_a = a_q[EntW-1] ? EntNone : jt_rdata_a;
  assign hop_b = b_q[EntW-1] ? EntNone : jt_rdata_b;

  always_comb begin
    if (dep_rdata_a > dep_rdata_b) begin
      dep_diff = dep_rdata_a - dep_rdata_b;
    end else begin
      dep_diff = dep_rdata_b - dep_rdata_a;
    end
  end

  lca_ram #(
    .Width (EntW),
    .Depth (JtDepth)
  ) u_jump_ram (
    .clk_i     (clk_i),
    .we_i      (jt_we),
    .waddr_i   (jt_waddr),
    .wdata_i   (jt_wdata),
    .raddr_a_i (jt_raddr_a),
    .rdata_a_o (jt_rdata_a),
    .raddr_b_i (jt_raddr_b),
    .rdata_b_o (jt_rdata_b)
  );

  lca_ram #(
    .Width (lca_pkg::DepthFieldW),
    .Depth (NODES)
  ) u_depth_ram (
    .clk_i     (clk_i),
    .we_i      (dep_we),
    .waddr_i   (dep_waddr),
    .wdata_i   (dep_wdata),
    .raddr_a_i (dep_raddr_a),
    .rdata_a_o (dep_rdata_a),
    .raddr_b_i (dep_raddr_b),
    .rdata_b_o (dep_rdata_b)
  );

  assign s_axis_tready_o = (state_q == lca_pkg::ST_IDLE);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_anc_d   = out_anc_q;
    out_query_d = out_query_q;
    k_d         = k_q;
    v_d         = v_q;
    last_d      = last_q;
    a_d         = a_q;
    b_d         = b_q;
    p_d         = p_q;
    res_d       = res_q;
    query_d     = query_q;
    diff_d      = diff_q;
    jt_we       = 1'b0;
    jt_waddr    = JtAw'({k_inc, v_q});
    jt_wdata    = EntNone;
    jt_raddr_a  = JtAw'({k_q, a_q[NodeW-1:0]});
    jt_raddr_b  = JtAw'({k_q, b_q[NodeW-1:0]});
    dep_we      = 1'b0;
    dep_waddr   = NodeW'(in_first);
    dep_wdata   = in_depth;
    // Depths of both query nodes are read while waiting for a word.
    dep_raddr_a = NodeW'(in_first);
    dep_raddr_b = NodeW'(in_second);

    case (state_q)
      lca_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          res_d   = EntNone;
          query_d = 1'b0;
          state_d = lca_pkg::ST_FINISH;
          case (in_op)
            lca_pkg::OP_LOAD: begin
              if (in_first_ok) begin
                jt_we    = 1'b1;
                jt_waddr = JtAw'({LvlW'(0), NodeW'(in_first)});
                jt_wdata = in_parent_ent;
                dep_we   = 1'b1;
              end
            end
            lca_pkg::OP_BUILD: begin
              last_d = NodeW'(last_cmp);
              k_d    = '0;
              v_d    = NodeW'(1);
              if (last_cmp != '0 && LEVELS > 1) begin
                state_d = lca_pkg::ST_BRD1;
              end
            end
            lca_pkg::OP_QUERY: begin
              query_d = 1'b1;
              a_d     = {1'b0, NodeW'(in_first)};
              b_d     = {1'b0, NodeW'(in_second)};
              if (in_first_ok && in_second_ok) begin
                state_d = lca_pkg::ST_QDEP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      lca_pkg::ST_BRD1: begin
        jt_raddr_a = JtAw'({k_q, v_q});
        state_d    = lca_pkg::ST_BRD2;
      end

      lca_pkg::ST_BRD2: begin
        p_d        = jt_rdata_a;
        jt_raddr_a = JtAw'({k_q, jt_rdata_a[NodeW-1:0]});
        state_d    = lca_pkg::ST_BWR;
      end

      lca_pkg::ST_BWR: begin
        jt_we    = 1'b1;
        jt_waddr = JtAw'({k_inc, v_q});
        jt_wdata = p_q[EntW-1] ? EntNone : jt_rdata_a;
        state_d  = lca_pkg::ST_BRD1;
        if (v_q == last_q) begin
          if (k_q == LvlBuildLast) begin
            state_d = lca_pkg::ST_FINISH;
          end else begin
            k_d = k_inc;
            v_d = NodeW'(1);
          end
        end else begin
          v_d = v_q + NodeW'(1);
        end
      end

      lca_pkg::ST_QDEP: begin
        // The deeper node goes to b.
        if (dep_rdata_a > dep_rdata_b) begin
          a_d = b_q;
          b_d = a_q;
        end
        diff_d  = LEVELS'(dep_diff);
        k_d     = '0;
        state_d = lca_pkg::ST_LIFT;
      end

      lca_pkg::ST_LIFT: begin
        jt_raddr_a = JtAw'({k_q, b_q[NodeW-1:0]});
        if (diff_q == '0) begin
          state_d = lca_pkg::ST_CHECK;
        end else if (diff_q[0] && !b_q[EntW-1]) begin
          state_d = lca_pkg::ST_LIFTW;
        end else begin
          diff_d = diff_q >> 1;
          k_d    = k_inc;
        end
      end

      lca_pkg::ST_LIFTW: begin
        b_d     = jt_rdata_a;
        diff_d  = diff_q >> 1;
        k_d     = k_inc;
        state_d = lca_pkg::ST_LIFT;
      end

      lca_pkg::ST_CHECK: begin
        if (a_q == b_q) begin
          res_d   = a_q;
          state_d = lca_pkg::ST_FINISH;
        end else begin
          k_d     = LvlLast;
          state_d = lca_pkg::ST_DOWN;
        end
      end

      lca_pkg::ST_DOWN: begin
        state_d = lca_pkg::ST_DOWNW;
      end

      lca_pkg::ST_DOWNW: begin
        if (hop_a != hop_b) begin
          a_d = hop_a;
          b_d = hop_b;
        end
        if (k_q == '0) begin
          state_d = lca_pkg::ST_FINRD;
        end else begin
          k_d     = k_dec;
          state_d = lca_pkg::ST_DOWN;
        end
      end

      lca_pkg::ST_FINRD: begin
        jt_raddr_a = JtAw'({LvlW'(0), a_q[NodeW-1:0]});
        state_d    = lca_pkg::ST_FINW;
      end

      lca_pkg::ST_FINW: begin
        res_d   = hop_a;
        state_d = lca_pkg::ST_FINISH;
      end

      lca_pkg::ST_FINISH: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_anc_d   = res_q[EntW-1] ? '1 : lca_pkg::AncestorW'(res_q[NodeW-1:0]);
          out_query_d = query_q;
          state_d     = lca_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lca_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lca_pkg::ST_IDLE;
      out_valid_q  <= 1'b0;
      node_count_q <= lca_pkg::NodeCountReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_anc_q   <= out_anc_d;
    out_query_q <= out_query_d;
    k_q         <= k_d;
    v_q         <= v_d;
    last_q      <= last_d;
    a_q         <= a_d;
    b_q         <= b_d;
    p_q         <= p_d;
    res_q       <= res_d;
    query_q     <= query_d;
    diff_q      <= diff_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = lca_pkg::OutDataW'(out_anc_q);
  assign m_axis_tuser_o  = out_query_q;

`ifndef SYNTH
  // The shallower node is a real node until the top-down phase starts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lca_pkg::ST_LIFT || state_q == lca_pkg::ST_LIFTW ||
     state_q == lca_pkg::ST_CHECK) |-> !a_q[EntW-1])
    else $error("shallow node became none before the top-down phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    jt_we |-> (state_q == lca_pkg::ST_IDLE || state_q == lca_pkg::ST_BWR))
    else $error("jump table written outside load or build");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lca_pkg::ST_FINISH && (!out_valid_q || m_axis_tready_i)) |=>
    (out_valid_q && state_q == lca_pkg::ST_IDLE))
    else $error("finished result not moved to the output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lca_pkg::ST_BRD1) |-> (v_q != '0 && v_q <= last_q))
    else $error("build node index out of range");
`endif

endmodule

@@ verif/lowest_common_ancestor_engine_unit_tb.sv @@
// Self-checking testbench for lowest_common_ancestor_engine_unit.
// Needs lca_pkg and the engine RTL; keeps its own jump table and depth copy to predict answers.
`timescale 1ns / 100ps

module lowest_common_ancestor_engine_unit_tb;

  // Nodes 1..TreeNodes are loaded early and every later build and query stays inside them.
  localparam int TreeNodes = 300;

  typedef struct {
    lca_pkg::op_e                     op;
    logic [lca_pkg::NodeFieldW-1:0]   first_node;
    logic [lca_pkg::NodeFieldW-1:0]   second_node;
    logic [lca_pkg::ParentFieldW-1:0] node_parent;
    logic [lca_pkg::DepthFieldW-1:0]  node_depth;
  } lca_word_t;

  typedef struct {
    logic [lca_pkg::AncestorW-1:0] ancestor;
    logic                          was_query;
  } answer_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [lca_pkg::NodeCountW-1:0] cfg_wdata_i = '0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [lca_pkg::InDataW-1:0]    s_axis_tdata_i = '0;
  logic [1:0]                     s_axis_tuser_i = '0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [lca_pkg::OutDataW-1:0]   m_axis_tdata_o;
  logic [0:0]                     m_axis_tuser_o;

  lowest_common_ancestor_engine_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the engine state.
  int lift_table [lca_pkg::LevelsDefault][lca_pkg::NodesDefault];
  int depth_mem [lca_pkg::NodesDefault];
  int count_reg = lca_pkg::NodeCountReset;

  answer_t answer_q[$];
  int errors = 0;
  int words_sent = 0;
  int queries_sent = 0;
  int results_checked = 0;
  bit steady = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic int hop_up(int level, int x);
    if (x < 0 || x >= lca_pkg::NodesDefault || level >= lca_pkg::LevelsDefault) return -1;
    return lift_table[level][x];
  endfunction

  function automatic int common_root(int a, int b);
    int t;
    int diff;
    int k;
    int pa;
    int pb;
    if (depth_mem[a] > depth_mem[b]) begin
      t = a;
      a = b;
      b = t;
    end
    diff = depth_mem[b] - depth_mem[a];
    for (k = 0; k < lca_pkg::LevelsDefault; k++) begin
      if (((diff >> k) & 1) != 0) b = hop_up(k, b);
    end
    if (a == b) return a;
    for (k = lca_pkg::LevelsDefault - 1; k >= 0; k--) begin
      pa = hop_up(k, a);
      pb = hop_up(k, b);
      if (pa != pb) begin
        a = pa;
        b = pb;
      end
    end
    return hop_up(0, a);
  endfunction

  function automatic answer_t predict_answer(lca_word_t w);
    answer_t ans;
    int p;
    int last;
    int k;
    int v;
    ans.ancestor  = '1;
    ans.was_query = 1'b0;
    case (w.op)
      lca_pkg::OP_LOAD: begin
        p = int'($signed(w.node_parent));
        if (p < 0 || p >= lca_pkg::NodesDefault) p = -1;
        lift_table[0][w.first_node] = p;
        depth_mem[w.first_node] = w.node_depth;
      end
      lca_pkg::OP_BUILD: begin
        last = (count_reg > lca_pkg::NodesDefault - 1) ? lca_pkg::NodesDefault - 1 : count_reg;
        for (k = 0; k + 1 < lca_pkg::LevelsDefault; k++) begin
          for (v = 1; v <= last; v++) lift_table[k + 1][v] = hop_up(k, lift_table[k][v]);
        end
      end
      lca_pkg::OP_QUERY: begin
        ans.was_query = 1'b1;
        ans.ancestor  = lca_pkg::AncestorW'(common_root(int'(w.first_node),
                                                        int'(w.second_node)));
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Fields a word does not use are filled with random bits.
  function automatic lca_word_t make_load(int node, int parent, int depth);
    lca_word_t w;
    w.op          = lca_pkg::OP_LOAD;
    w.first_node  = lca_pkg::NodeFieldW'(node);
    w.second_node = lca_pkg::NodeFieldW'($urandom);
    w.node_parent = lca_pkg::ParentFieldW'(parent);
    w.node_depth  = lca_pkg::DepthFieldW'(depth);
    return w;
  endfunction

  function automatic lca_word_t make_query(int a, int b);
    lca_word_t w;
    w.op          = lca_pkg::OP_QUERY;
    w.first_node  = lca_pkg::NodeFieldW'(a);
    w.second_node = lca_pkg::NodeFieldW'(b);
    w.node_parent = lca_pkg::ParentFieldW'($urandom);
    w.node_depth  = lca_pkg::DepthFieldW'($urandom);
    return w;
  endfunction

  function automatic lca_word_t make_other(lca_pkg::op_e op);
    lca_word_t w;
    w.op          = op;
    w.first_node  = lca_pkg::NodeFieldW'($urandom);
    w.second_node = lca_pkg::NodeFieldW'($urandom);
    w.node_parent = lca_pkg::ParentFieldW'($urandom);
    w.node_depth  = lca_pkg::DepthFieldW'($urandom);
    return w;
  endfunction

  // Never zero: node 0 has no built levels, so it must never be reached by lifting.
  function automatic int random_parent();
    if ($urandom_range(0, 3) == 0) return -int'($urandom_range(1, 1024));
    return $urandom_range(1, TreeNodes);
  endfunction

  // Called at a rising edge; returns at the edge where the word was accepted.
  task automatic send_word(input lca_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(lca_pkg::InDataW - 41){1'b0}}, w.node_depth, w.node_parent,
                        w.second_node, w.first_node};
    s_axis_tuser_i  <= w.op;
    do @(negedge clk_i); while (s_axis_tready_o !== 1'b1);
    @(posedge clk_i);
    answer_q = {answer_q, predict_answer(w)};
    words_sent++;
    if (w.op == lca_pkg::OP_QUERY) queries_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_node_count(input int value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lca_pkg::NodeCountW'(value);
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    count_reg = value & 'h7FF;
  endtask

  // Loads nodes 1..count as a forest; root_pct sets how often a node starts a new tree.
  task automatic load_tree(input int count, input bit true_depth, input bit shuffled,
                           input int root_pct);
    int up [lca_pkg::NodesDefault];
    int lvl [lca_pkg::NodesDefault];
    int order [lca_pkg::NodesDefault];
    int i;
    int j;
    int t;
    for (i = 1; i <= count; i++) begin
      if (i == 1 || $urandom_range(0, 99) < root_pct)
        up[i] = ($urandom_range(0, 1) == 0) ? -1 : -int'($urandom_range(1, 1024));
      else if ($urandom_range(0, 9) < 6)
        up[i] = i - 1;
      else
        up[i] = $urandom_range(1, i - 1);
      lvl[i]   = (up[i] < 0) ? 0 : lvl[up[i]] + 1;
      order[i] = i;
    end
    if (shuffled) begin
      for (i = count; i > 1; i--) begin
        j        = $urandom_range(1, i);
        t        = order[i];
        order[i] = order[j];
        order[j] = t;
      end
    end
    for (i = 1; i <= count; i++) begin
      send_word(make_load(order[i], up[order[i]],
                          true_depth ? lvl[order[i]] : $urandom_range(0, 1023)));
    end
  endtask

  // Words that touch no jump table level above the direct parent.
  task automatic test_loads_and_nop();
    send_word(make_load(0, -5, 0));
    send_word(make_query(0, 0));
    send_word(make_other(lca_pkg::OP_NOP));
    send_word(make_load(1023, 1023, 1023));
    send_word(make_load(1022, -1024, 0));
    send_word(make_load(1021, -1, 1023));
  endtask

  // Deep tree over the first TreeNodes nodes, built with a count that covers all of them.
  task automatic test_deep_tree();
    int i;
    load_tree(TreeNodes, 1'b1, 1'b0, 0);
    drain_results();
    write_node_count(TreeNodes);
    send_word(make_other(lca_pkg::OP_BUILD));
    send_word(make_query(1, TreeNodes));
    send_word(make_query(TreeNodes, TreeNodes));
    send_word(make_query(TreeNodes / 2, 1));
    for (i = 0; i < 20; i++)
      send_word(make_query($urandom_range(1, TreeNodes), $urandom_range(1, TreeNodes)));
  endtask

  task automatic test_node_count_extremes();
    int i;
    drain_results();
    write_node_count(0);
    send_word(make_other(lca_pkg::OP_BUILD));
    send_word(make_query(5, TreeNodes));
    drain_results();
    write_node_count(1);
    send_word(make_load(1, -1, 0));
    send_word(make_other(lca_pkg::OP_BUILD));
    send_word(make_query(1, 1));
    send_word(make_query(1, TreeNodes));
    drain_results();
    // A parent numbered above its child, rebuilt over nodes 1..TreeNodes.
    write_node_count(TreeNodes);
    send_word(make_load(2, TreeNodes, 5));
    send_word(make_other(lca_pkg::OP_BUILD));
    send_word(make_query(2, TreeNodes));
    for (i = 0; i < 6; i++)
      send_word(make_query($urandom_range(1, TreeNodes), $urandom_range(1, TreeNodes)));
  endtask

  // Small forests, each built and then queried, with stray words mixed in.
  task automatic test_random_forests();
    int start;
    int c;
    int q;
    int i;
    start = words_sent;
    while (words_sent - start < 200) begin
      c = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 64) : $urandom_range(2, 24);
      drain_results();
      steady = ($urandom_range(0, 5) == 0);
      write_node_count(($urandom_range(0, 4) == 0) ? c + $urandom_range(0, 40) : c);
      load_tree(c, $urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0,
                ($urandom_range(0, 1) == 0) ? 0 : 5);
      send_word(make_other(lca_pkg::OP_BUILD));
      q = $urandom_range(6, 20);
      for (i = 0; i < q; i++) begin
        case ($urandom_range(0, 19))
          0: send_word(make_other(lca_pkg::OP_NOP));
          1: send_word(make_load($urandom_range(1, TreeNodes), random_parent(),
                                 $urandom_range(0, 1023)));
          2: send_word(make_query($urandom_range(1, TreeNodes),
                                  $urandom_range(1, TreeNodes)));
          3: send_word(make_other(lca_pkg::OP_BUILD));
          4: drain_results();
          default: send_word(make_query($urandom_range(1, c), $urandom_range(1, c)));
        endcase
      end
    end
    steady = 1'b0;
  endtask

  initial begin : ready_driver
    int hold;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        m_axis_tready_i <= 1'b0;
        hold--;
      end else begin
        m_axis_tready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  // Inputs and outputs only move at the rising edge, so the falling edge shows
  // exactly what the next rising edge will transfer.
  always @(negedge clk_i) begin : result_check
    answer_t want;
    if (rst_ni === 1'b1 && m_axis_tvalid_o === 1'b1 && m_axis_tready_i === 1'b1) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual ancestor %0d",
                 $time, $signed(m_axis_tdata_o[lca_pkg::AncestorW-1:0]));
        errors++;
      end else begin
        want = answer_q.pop_front();
        results_checked++;
        if (m_axis_tdata_o[lca_pkg::AncestorW-1:0] !== want.ancestor) begin
          $display("%0t: ancestor mismatch, expected %0d, actual %0d", $time,
                   $signed(want.ancestor), $signed(m_axis_tdata_o[lca_pkg::AncestorW-1:0]));
          errors++;
        end
        if (m_axis_tuser_o[0] !== want.was_query) begin
          $display("%0t: was_query mismatch, expected %0b, actual %0b", $time,
                   want.was_query, m_axis_tuser_o[0]);
          errors++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_loads_and_nop();
    test_deep_tree();
    test_node_count_extremes();
    test_random_forests();
    drain_results();
    repeat (20) @(posedge clk_i);
    if (answer_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, answer_q.size());
      errors++;
    end
    $display("Checked %0d results from %0d words, %0d of them common ancestor queries,",
             results_checked, words_sent, queries_sent);
    $display("over a %0d-node tree, node counts 0 and 1, and random forests.", TreeNodes);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/lca_pkg.sv
hw/rtl/lca_ram.sv
hw/rtl/lowest_common_ancestor_engine_unit.sv
verif/lowest_common_ancestor_engine_unit_tb.sv
